/* hw/rtl/qve_pkg.sv */
// ----------------------------------------------------------------------------
// qve_pkg
// shared types and constants of the quadrature velocity estimator
// ----------------------------------------------------------------------------
`default_nettype none

package qve_pkg;

    // stream payload widths
    localparam int IN_DATA_W  = 24;   // level_a, level_b, period, zero fill
    localparam int OUT_DATA_W = 80;   // velocity, angle

    // field widths
    localparam int PERIOD_W = 20;
    localparam int VEL_W    = 32;
    localparam int ANGLE_W  = 48;
    localparam int RPC_W    = 24;
    localparam int FF_W     = 16;

    // configuration port
    localparam int               CFG_IDX_W  = 2;
    localparam int               CFG_DATA_W = 24;
    localparam [CFG_IDX_W-1:0]   REG_RPC    = 2'd0;
    localparam [CFG_IDX_W-1:0]   REG_FF     = 2'd1;
    localparam [RPC_W-1:0]       RPC_RESET  = 24'd1608;
    localparam [FF_W-1:0]        FF_RESET   = 16'd62259;

    // item kinds carried in tuser
    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // arithmetic
    localparam int           MAG_MAX_W  = 56;            // widest |count| * rpc
    localparam int           RATE_NUM_W = 14;
    localparam [RATE_NUM_W-1:0] RATE_NUM = 14'd15625;    // 10^6 / 64
    localparam int           NUM_W      = MAG_MAX_W + RATE_NUM_W;
    localparam int           DIVSR_W    = 22;            // 4 * period
    localparam [31:0]        WEIGHT_ONE = 32'h0001_0000;

    // shared divider step
    localparam int           DIV_W      = 32;
    localparam int           ITER_W     = 5;
    localparam [ITER_W-1:0]  ITER_LAST  = 5'(DIV_W - 1);

    typedef struct packed {
        logic [DIV_W-1:0] rem;   // partial remainder
        logic [DIV_W-1:0] acc;   // dividend bits out at the top, quotient bits in below
    } div_t;

endpackage

`default_nettype wire

/* hw/rtl/qve_div_step.sv */
// ----------------------------------------------------------------------------
// qve_div_step
// one restoring division step, shared by both divisions of a sample tick
// ----------------------------------------------------------------------------
`default_nettype none

module qve_div_step (
    input  wire qve_pkg::div_t               cur,
    input  wire logic [qve_pkg::DIV_W-1:0]   divisor,
    output qve_pkg::div_t                    nxt
);

    logic [qve_pkg::DIV_W:0] shifted;
    logic [qve_pkg::DIV_W:0] trial;
    logic                    ge;

    always_comb
    begin
        shifted = {cur.rem, cur.acc[qve_pkg::DIV_W-1]};
        ge      = shifted >= {1'b0, divisor};
        trial   = shifted - {1'b0, divisor};
        nxt.rem = ge ? trial[qve_pkg::DIV_W-1:0] : shifted[qve_pkg::DIV_W-1:0];
        nxt.acc = {cur.acc[qve_pkg::DIV_W-2:0], ge};
    end

endmodule

`default_nettype wire

/* hw/rtl/quadrature_velocity_estimator.sv */
// ----------------------------------------------------------------------------
// quadrature_velocity_estimator
// encoder edge counter, angle accumulator and forgetting-average velocity
// ----------------------------------------------------------------------------
// encoder edge transaction: no result, the block stays ready for the next transaction
// sample tick transaction: result goes through MUL1, MUL2, LD1, DIV1, VEL, DIV2 and FIN,
//   two 32-step passes through the single shared divider step; FIN holds under backpressure
// throughput: one edge per cycle while idle; a tick blocks new items until its result is out
// reset: async active low, clears count, angle, velocity, weight, output valid;
//   registers go back to radians_per_count 1608 and forgetting_factor 62259
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_velocity_estimator #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // input stream
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [qve_pkg::IN_DATA_W-1:0]     s_tdata,   // level_a, level_b, sample_period_us[19:0], pad
    input  wire logic                              s_tuser,   // operation

    // result stream
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [qve_pkg::OUT_DATA_W-1:0]         m_tdata,   // angular_velocity[31:0], angle[47:0]

    // configuration
    input  wire logic                              cfg_write,
    input  wire logic [qve_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [qve_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int MAG_W = COUNT_WIDTH + qve_pkg::RPC_W;

    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

    // sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;   // takes transactions
    localparam logic [2:0] ST_MUL1 = 3'd1;   // step magnitude, weight product
    localparam logic [2:0] ST_MUL2 = 3'd2;   // rate numerator, angle, weight
    localparam logic [2:0] ST_LD1  = 3'd3;   // set up rate division
    localparam logic [2:0] ST_DIV1 = 3'd4;   // rate = numerator / (4 * period)
    localparam logic [2:0] ST_VEL  = 3'd5;   // clamp rate, form difference
    localparam logic [2:0] ST_DIV2 = 3'd6;   // delta = |diff| * 2^16 / weight
    localparam logic [2:0] ST_FIN  = 3'd7;   // apply delta, present result

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    logic [2:0]                          state_reg, state_next;
    logic signed [COUNT_WIDTH-1:0]       count_reg, count_next;
    logic [qve_pkg::ANGLE_W-1:0]         angle_reg, angle_next;
    logic signed [qve_pkg::VEL_W-1:0]    vel_reg, vel_next;
    logic [31:0]                         weight_reg, weight_next;
    logic [qve_pkg::RPC_W-1:0]           rpc_reg, rpc_next;
    logic [qve_pkg::FF_W-1:0]            ff_reg, ff_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [qve_pkg::OUT_DATA_W-1:0]      out_reg, out_next;

    // working registers of one tick, no reset needed
    logic [qve_pkg::PERIOD_W-1:0]        period_reg, period_next;
    logic                                neg_reg, neg_next;      // sign of the step
    logic [MAG_W-1:0]                    mag_reg, mag_next;      // |count| * rpc, Q.24
    logic [47:0]                         wprod_reg, wprod_next;  // lambda * weight
    logic [qve_pkg::NUM_W-1:0]           num_reg, num_next;      // |step| * 15625
    logic [qve_pkg::DIVSR_W-1:0]         dvs_reg, dvs_next;      // 4 * period
    logic                                sat_reg, sat_next;      // rate quotient too big
    logic                                dneg_reg, dneg_next;    // sign of rate - velocity
    qve_pkg::div_t                       div_reg, div_next;
    logic [qve_pkg::ITER_W-1:0]          iter_reg, iter_next;

    // ------------------------------------------------------------------
    // shared divider step
    // ------------------------------------------------------------------
    logic [qve_pkg::DIV_W-1:0] divisor;
    qve_pkg::div_t             div_step;

    assign divisor = (state_reg == ST_DIV2) ? weight_reg
                                            : qve_pkg::DIV_W'(dvs_reg);

    qve_div_step u_div_step (
        .cur     (div_reg),
        .divisor (divisor),
        .nxt     (div_step)
    );

    // ------------------------------------------------------------------
    // datapath and sequencer
    // ------------------------------------------------------------------
    logic                                accept;
    logic                                level_a;
    logic                                level_b;
    logic [qve_pkg::PERIOD_W-1:0]        period_in;
    logic [COUNT_WIDTH-1:0]              count_abs;
    logic [qve_pkg::MAG_MAX_W-1:0]       mag_wide;
    logic [qve_pkg::MAG_MAX_W:0]         mag_round;
    logic [32:0]                         weight_sum;
    logic [qve_pkg::PERIOD_W-1:0]        period_nz;
    logic [31:0]                         rate_mag;
    logic [33:0]                         rate_s;
    logic [33:0]                         diff_s;
    logic [33:0]                         diff_abs;
    logic [33:0]                         delta_s;
    logic [33:0]                         vel_sum;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign level_a   = s_tdata[0];
    assign level_b   = s_tdata[1];
    assign period_in = s_tdata[qve_pkg::PERIOD_W+1:2];

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        angle_next    = angle_reg;
        vel_next      = vel_reg;
        weight_next   = weight_reg;
        rpc_next      = rpc_reg;
        ff_next       = ff_reg;
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        period_next   = period_reg;
        neg_next      = neg_reg;
        mag_next      = mag_reg;
        wprod_next    = wprod_reg;
        num_next      = num_reg;
        dvs_next      = dvs_reg;
        sat_next      = sat_reg;
        dneg_next     = dneg_reg;
        div_next      = div_reg;
        iter_next     = iter_reg;

        count_abs  = count_reg[COUNT_WIDTH-1] ? COUNT_WIDTH'(-count_reg) : count_reg;
        mag_wide   = qve_pkg::MAG_MAX_W'(mag_reg);
        mag_round  = {1'b0, mag_wide} + (qve_pkg::MAG_MAX_W+1)'(128);
        weight_sum = {1'b0, wprod_reg[47:16]} + {1'b0, qve_pkg::WEIGHT_ONE};
        period_nz  = (period_reg == '0) ? qve_pkg::PERIOD_W'(1) : period_reg;

        // rate magnitude clamped so the signed value stays in 32 bits
        if (neg_reg)
            rate_mag = (sat_reg || div_reg.acc > 32'h8000_0000) ? 32'h8000_0000
                                                                 : div_reg.acc;
        else
            rate_mag = (sat_reg || div_reg.acc[31]) ? 32'h7FFF_FFFF : div_reg.acc;
        rate_s   = neg_reg ? -{2'b00, rate_mag} : {2'b00, rate_mag};
        diff_s   = rate_s - {{2{vel_reg[31]}}, vel_reg};
        diff_abs = diff_s[33] ? -diff_s : diff_s;

        delta_s  = dneg_reg ? -{2'b00, div_reg.acc} : {2'b00, div_reg.acc};
        vel_sum  = {{2{vel_reg[31]}}, vel_reg} + delta_s;

        // result drains independently of the sequencer
        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        // configuration writes: the user must write only while idle, the block itself does not enforce it
        if (cfg_write)
        begin
            case (cfg_index)
                qve_pkg::REG_RPC: rpc_next = cfg_data[qve_pkg::RPC_W-1:0];
                qve_pkg::REG_FF:  ff_next  = cfg_data[qve_pkg::FF_W-1:0];
                default:          ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == qve_pkg::OP_TICK)
                    begin
                        period_next = period_in;
                        state_next  = ST_MUL1;
                    end
                    else if (level_a != level_b)
                    begin
                        if (count_reg != CNT_MAX)
                            count_next = count_reg + COUNT_WIDTH'(1);
                    end
                    else
                    begin
                        if (count_reg != CNT_MIN)
                            count_next = count_reg - COUNT_WIDTH'(1);
                    end
                end
            end

            ST_MUL1:
            begin
                neg_next   = count_reg[COUNT_WIDTH-1];
                mag_next   = MAG_W'(count_abs) * MAG_W'(rpc_reg);
                wprod_next = 48'(ff_reg) * 48'(weight_reg);
                count_next = '0;
                state_next = ST_MUL2;
            end

            ST_MUL2:
            begin
                num_next = qve_pkg::NUM_W'(mag_wide) * qve_pkg::NUM_W'(qve_pkg::RATE_NUM);
                // angle step rounded half away from zero, Q.24 to Q.16
                if (neg_reg)
                    angle_next = angle_reg - mag_round[qve_pkg::ANGLE_W+7:8];
                else
                    angle_next = angle_reg + mag_round[qve_pkg::ANGLE_W+7:8];
                weight_next = weight_sum[32] ? 32'hFFFF_FFFF : weight_sum[31:0];
                dvs_next    = {period_nz, 2'b00};
                state_next  = ST_LD1;
            end

            ST_LD1:
            begin
                // quotient of 2^32 or more saturates the rate outright
                sat_next     = num_reg[qve_pkg::NUM_W-1:32] >=
                               (qve_pkg::NUM_W-32)'(dvs_reg);
                div_next.rem = qve_pkg::DIV_W'(num_reg[32+qve_pkg::DIVSR_W-1:32]);
                div_next.acc = num_reg[31:0];
                iter_next    = '0;
                state_next   = ST_DIV1;
            end

            ST_DIV1:
            begin
                div_next  = div_step;
                iter_next = iter_reg + qve_pkg::ITER_W'(1);
                if (iter_reg == qve_pkg::ITER_LAST)
                    state_next = ST_VEL;
            end

            ST_VEL:
            begin
                // |diff| < 2^32 and weight >= 1.0, so the top half is already reduced
                dneg_next    = diff_s[33];
                div_next.rem = {16'h0000, diff_abs[31:16]};
                div_next.acc = {diff_abs[15:0], 16'h0000};
                iter_next    = '0;
                state_next   = ST_DIV2;
            end

            ST_DIV2:
            begin
                div_next  = div_step;
                iter_next = iter_reg + qve_pkg::ITER_W'(1);
                if (iter_reg == qve_pkg::ITER_LAST)
                    state_next = ST_FIN;
            end

            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    if (!vel_sum[33] && vel_sum[32:31] != 2'b00)
                        vel_next = 32'sh7FFF_FFFF;
                    else if (vel_sum[33] && vel_sum[32:31] != 2'b11)
                        vel_next = 32'sh8000_0000;
                    else
                        vel_next = vel_sum[31:0];
                    out_next      = {angle_reg, vel_next};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            angle_reg    <= '0;
            vel_reg      <= '0;
            weight_reg   <= '0;
            rpc_reg      <= qve_pkg::RPC_RESET;
            ff_reg       <= qve_pkg::FF_RESET;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            angle_reg    <= angle_next;
            vel_reg      <= vel_next;
            weight_reg   <= weight_next;
            rpc_reg      <= rpc_next;
            ff_reg       <= ff_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload and working registers
    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        period_reg <= period_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        wprod_reg  <= wprod_next;
        num_reg    <= num_next;
        dvs_reg    <= dvs_next;
        sat_reg    <= sat_next;
        dneg_reg   <= dneg_next;
        div_reg    <= div_next;
        iter_reg   <= iter_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------

    // a tick transaction always makes the block busy on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tuser == qve_pkg::OP_TICK) |=> !s_tready)
        else $error("tick did not start the sequencer");

    // the count is cleared before the rate division runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV1) |-> (count_reg == '0))
        else $error("edge count not cleared during tick");

    // once updated the weight never falls below one
    assert property (@(posedge clk) disable iff (!rst_n)
        (weight_reg != '0) |-> (weight_reg >= qve_pkg::WEIGHT_ONE))
        else $error("average weight below one");

    // a division pass runs all its steps before moving on
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV1 || state_reg == ST_DIV2) && iter_reg != qve_pkg::ITER_LAST)
        |=> (state_reg == $past(state_reg)))
        else $error("division pass cut short");

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the quadrature velocity estimator: encoder edges and
// sample ticks go in over the input stream, each tick result is checked field
// by field against a cycle-free model of count, angle, weight and velocity
// ----------------------------------------------------------------------------

module testbench;

    import qve_pkg::*;

    localparam int COUNT_W       = 16;
    localparam int TICK_LATENCY  = 80;
    localparam int STALL_LIMIT   = 20000;   // cycles with no transaction before giving up
    localparam int RANDOM_ITEMS  = 1440;
    localparam int SEGMENTS      = 6;
    localparam int SAT_EDGES     = 120;     // one-way run long enough to clamp the rate

    // register indexes past the second one, writes there must do nothing
    localparam [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // 10^6 / 64, rate numerator once the 256 * period divisor is split as 4 * period
    localparam longint US_SCALE = 15625;

    typedef struct {
        logic signed [VEL_W-1:0] velocity;
        logic [ANGLE_W-1:0]      angle;
    } tick_result_t;

    // ------------------------------------------------------------------------
    // estimator model: edge counter, angle, forgetting-average velocity, plus
    // the queue of tick results the block still owes us
    // ------------------------------------------------------------------------
    class encoder_velocity_model;
        bit [RPC_W-1:0]          rad_per_count;
        bit [FF_W-1:0]           lambda;
        longint                  edge_count;
        bit [ANGLE_W-1:0]        angle;
        longint                  velocity;
        bit [31:0]               weight;
        tick_result_t            tick_results_due[$];
        int                      failures;

        function new();
            rad_per_count = RPC_RESET;
            lambda        = FF_RESET;
            edge_count    = 0;
            angle         = '0;
            velocity      = 0;
            weight        = '0;
            failures      = 0;
        endfunction

        function void write_register(bit [CFG_IDX_W-1:0] index, bit [CFG_DATA_W-1:0] data);
            if (index == REG_RPC)
                rad_per_count = data[RPC_W-1:0];
            else if (index == REG_FF)
                lambda = data[FF_W-1:0];
        endfunction

        static function longint clamp_vel(longint v);
            if (v > longint'(32'sh7FFF_FFFF))
                return longint'(32'sh7FFF_FFFF);
            if (v < -(longint'(1) << 31))
                return -(longint'(1) << 31);
            return v;
        endfunction

        // one accepted input transaction
        function void take_item(bit op, bit a, bit b, bit [PERIOD_W-1:0] period_us);
            longint       count_max;
            longint       step24;
            bit           neg;
            longint       mag;
            longint       smag;
            bit [63:0]    w;
            longint       div4;
            longint       quo;
            longint       rem;
            longint       rate;
            longint       delta;
            tick_result_t res;

            count_max = (longint'(1) << (COUNT_W - 1)) - 1;
            if (op == OP_EDGE) begin
                // differing levels count up, equal levels count down, pinned at the bounds
                if (a != b) begin
                    if (edge_count < count_max)
                        edge_count++;
                end
                else if (edge_count > -count_max - 1)
                    edge_count--;
                return;
            end

            step24 = edge_count * longint'(rad_per_count);
            neg    = step24 < 0;
            mag    = neg ? -step24 : step24;
            smag   = (mag + 128) >> 8;      // Q.24 to Q.16, ties away from zero
            edge_count = 0;
            angle  = neg ? angle - smag[ANGLE_W-1:0] : angle + smag[ANGLE_W-1:0];

            w = ((64'(lambda) * 64'(weight)) >> 16) + 64'(WEIGHT_ONE);
            if (w > 64'h0000_0000_FFFF_FFFF)
                w = 64'h0000_0000_FFFF_FFFF;
            weight = w[31:0];

            // zero period counts as one microsecond
            div4 = 4 * longint'((period_us == '0) ? 20'd1 : period_us);
            quo  = mag / div4;
            rem  = mag % div4;
            if (quo >= (longint'(1) << 33))
                rate = longint'(1) << 40;
            else
                rate = quo * US_SCALE + (rem * US_SCALE) / div4;
            rate = clamp_vel(neg ? -rate : rate);

            delta    = ((rate - velocity) * 65536) / longint'(w);
            velocity = clamp_vel(velocity + delta);

            res.velocity = velocity[VEL_W-1:0];
            res.angle    = angle;
            tick_results_due.push_back(res);
        endfunction

        function void check_tick_result(logic [OUT_DATA_W-1:0] data);
            tick_result_t            due;
            logic signed [VEL_W-1:0] got_velocity;
            logic [ANGLE_W-1:0]      got_angle;

            got_velocity = data[VEL_W-1:0];
            got_angle    = data[VEL_W +: ANGLE_W];
            if (tick_results_due.size() == 0) begin
                failures++;
                $display("%0t: result with nothing due, actual velocity %0d angle %0d",
                         $time, got_velocity, $signed(got_angle));
                return;
            end
            due = tick_results_due.pop_front();
            if (got_velocity !== due.velocity) begin
                failures++;
                $display("%0t: angular_velocity mismatch, expected %0d, actual %0d",
                         $time, due.velocity, got_velocity);
            end
            if (got_angle !== due.angle) begin
                failures++;
                $display("%0t: angle mismatch, expected %0d, actual %0d",
                         $time, $signed(due.angle), $signed(got_angle));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset, block
    // ------------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;

    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_W-1:0]     s_tdata = '0;
    logic                     s_tuser = OP_EDGE;

    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]    m_tdata;

    logic                     cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = REG_RPC;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;

    int                       send_idle_pct = 18;
    int                       recv_idle_pct = 85;

    encoder_velocity_model    estimator = new();

    always #4 clk = ~clk;

    quadrature_velocity_estimator #(
        .COUNT_WIDTH (COUNT_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // level_a, level_b, sample_period_us[19:0], zero fill
        .s_tuser   (s_tuser),     // operation
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // angular_velocity[31:0], angle[47:0]
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // result side: random backpressure at the falling edge, check at the rising
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            estimator.check_tick_result(m_tdata);
    end

    // watchdog: any stretch without a transaction on either stream is a hang
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("quadrature_velocity_estimator test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // drivers, all entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(input bit op, input bit a, input bit b,
                             input bit [PERIOD_W-1:0] period_us);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, period_us, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        estimator.take_item(op, a, b, period_us);
        @(negedge clk);
    endtask

    // write one register; only called while the block has nothing in flight
    task automatic write_register(input bit [CFG_IDX_W-1:0] index,
                                  input bit [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        estimator.write_register(index, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // wait out every owed result and whatever the last tick still has going
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (estimator.tick_results_due.size() != 0)
            @(negedge clk);
        repeat (TICK_LATENCY) @(negedge clk);
    endtask

    function automatic bit [PERIOD_W-1:0] pick_period();
        int roll;
        roll = $urandom_range(99);
        if (roll < 2)
            return '0;
        if (roll < 5)
            return '1;
        if (roll < 45)
            return PERIOD_W'($urandom_range(1, 200));
        if (roll < 75)
            return PERIOD_W'($urandom_range(1, 20000));
        return PERIOD_W'($urandom_range(0, 20'hFFFFF));
    endfunction

    // edge with levels that move the count the chosen way
    task automatic send_edge(input bit count_up);
        bit a;
        a = $urandom_range(1);
        send_item(OP_EDGE, a, count_up ? ~a : a, PERIOD_W'($urandom()));
    endtask

    // mostly edge bursts in one direction closed by a tick, some noise and lone ticks
    task automatic run_traffic(input int item_budget);
        int  sent;
        int  roll;
        int  burst;
        bit  dir;
        sent = 0;
        while (sent < item_budget) begin
            roll = $urandom_range(99);
            if (roll < 80) begin
                dir   = $urandom_range(1);
                burst = ($urandom_range(9) == 0) ? $urandom_range(120) : $urandom_range(8);
                for (int i = 0; i < burst; i++) begin
                    // occasional backstep, as with a shaft dithering on an edge
                    send_edge(($urandom_range(9) == 0) ? ~dir : dir);
                end
                send_item(OP_TICK, $urandom_range(1), $urandom_range(1), pick_period());
                sent += burst + 1;
            end
            else if (roll < 92) begin
                burst = $urandom_range(1, 6);
                for (int i = 0; i < burst; i++)
                    send_item(OP_EDGE, $urandom_range(1), $urandom_range(1),
                              PERIOD_W'($urandom()));
                sent += burst;
            end
            else begin
                send_item(OP_TICK, $urandom_range(1), $urandom_range(1), pick_period());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        bit [RPC_W-1:0] rpc_plan [SEGMENTS];
        bit [FF_W-1:0]  ff_plan  [SEGMENTS];

        rpc_plan = '{24'hFF_FFFF, 24'd0, RPC_W'($urandom()), RPC_RESET, 24'd1,
                     RPC_W'($urandom())};
        ff_plan  = '{16'd0, 16'hFFFF, FF_RESET, FF_W'($urandom()), 16'd1, FF_W'($urandom())};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed, reset register values
        send_item(OP_TICK, 1'b1, 1'b1, 20'd1);           // empty count, first weight step
        send_item(OP_EDGE, 1'b0, 1'b1, 20'hFFFFF);       // period ignored on an edge
        send_item(OP_EDGE, 1'b1, 1'b0, 20'd0);
        send_item(OP_TICK, 1'b0, 1'b0, 20'd1);           // shortest period
        send_item(OP_EDGE, 1'b0, 1'b0, 20'd5);
        send_item(OP_EDGE, 1'b1, 1'b1, 20'd0);
        send_item(OP_EDGE, 1'b0, 1'b0, 20'd0);
        send_item(OP_TICK, 1'b1, 1'b0, 20'd0);           // zero period taken as one
        send_item(OP_EDGE, 1'b1, 1'b0, 20'd0);
        send_item(OP_EDGE, 1'b0, 1'b1, 20'd0);
        send_item(OP_EDGE, 1'b1, 1'b0, 20'd0);
        send_item(OP_TICK, 1'b0, 1'b1, 20'hFFFFF);       // longest period
        send_item(OP_EDGE, 1'b1, 1'b1, 20'd0);
        send_item(OP_TICK, 1'b1, 1'b1, 20'd1000);

        // writes to unused indexes must leave both registers alone
        wait_idle();
        write_register(REG_SPARE_2, '1);
        write_register(REG_SPARE_3, '1);
        send_item(OP_EDGE, 1'b0, 1'b1, 20'd0);
        send_item(OP_TICK, 1'b0, 1'b0, 20'd3);

        // long one-way runs with the largest scale, rate clamps both ways
        wait_idle();
        write_register(REG_RPC, 24'hFF_FFFF);
        write_register(REG_FF, 16'hFFFF);
        for (int i = 0; i < SAT_EDGES; i++)
            send_edge(1'b1);
        send_item(OP_TICK, 1'b0, 1'b0, 20'd1);
        for (int i = 0; i < SAT_EDGES; i++)
            send_edge(1'b0);
        send_item(OP_TICK, 1'b1, 1'b0, 20'd1);
        send_item(OP_TICK, 1'b0, 1'b1, 20'd4);

        // random segments, each under its own register setting and one of three idling modes
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_idle();
            if (seg < 2) begin
                send_idle_pct = 18;
                recv_idle_pct = 85;
            end
            else if (seg < 4) begin
                send_idle_pct = 85;
                recv_idle_pct = 18;
            end
            else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_register(REG_RPC, rpc_plan[seg]);
            write_register(REG_FF, ff_plan[seg]);
            write_register($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                           CFG_DATA_W'($urandom()));
            run_traffic(RANDOM_ITEMS / SEGMENTS);
        end

        wait_idle();
        if (estimator.tick_results_due.size() != 0) begin
            estimator.failures++;
            $display("%0t: %0d results never arrived", $time,
                     estimator.tick_results_due.size());
        end
        if (estimator.failures == 0)
            $display("quadrature_velocity_estimator test passed");
        else
            $display("quadrature_velocity_estimator test failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/qve_pkg.sv
hw/rtl/qve_div_step.sv
hw/rtl/quadrature_velocity_estimator.sv
bench/testbench.sv
